// ===== rtl/vog_pkg.sv =====
// ----------------------------------------------------------------------------
// vog_pkg
// Shared types, sizes and register codes for the voxel occupancy grid.
// ----------------------------------------------------------------------------
package vog_pkg;

  localparam int X_CELLS = 64;
  localparam int Y_CELLS = 64;
  localparam int Z_CELLS = 32;

  localparam int XW    = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int YW    = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
  localparam int ZW    = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;
  localparam int IDX_W = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);

  localparam int ROWS   = X_CELLS * Y_CELLS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LIMIT_X   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LIMIT_Y   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LIMIT_Z   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_CELL_SIZE = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CELL_INV  = 3'd7;

  localparam logic [31:0] RST_ORIGIN    = 32'd0;
  localparam logic [31:0] RST_LIMIT_XY  = 32'd4194304;
  localparam logic [31:0] RST_LIMIT_Z   = 32'd2097152;
  localparam logic [31:0] RST_CELL_SIZE = 32'd65536;
  localparam logic [31:0] RST_CELL_INV  = 32'd65536;

  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic               func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic               is_free;
    logic        [5:0]  cell_x;
    logic        [5:0]  cell_y;
    logic        [4:0]  cell_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] limit_x;
    logic signed [31:0] limit_y;
    logic signed [31:0] limit_z;
    logic        [31:0] cell_size;
    logic        [31:0] cell_inv;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iy;
    logic [IDX_W-1:0] iz;
  } q_entry_t;

  function automatic logic [IDX_W-1:0] sat_idx(input logic [31:0] hi, input int cells);
    logic [31:0] top;
    top = 32'(cells - 1);
    if (hi > top) begin
      sat_idx = IDX_W'(top);
    end else begin
      sat_idx = hi[IDX_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/vog_front.sv =====
// ----------------------------------------------------------------------------
// vog_front
// Drops out-of-box marks, computes clamped voxel indices, feeds the queue.
// ----------------------------------------------------------------------------
module vog_front import vog_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_fire,
  input  in_t      in_data,
  input  logic     q_full,
  output logic     adv,
  output logic     q_push,
  output q_entry_t q_wdata
);

  logic        v1_r;
  logic        func1_r;
  logic [31:0] dx1_r, dy1_r, dz1_r;
  logic        v2_r;
  logic        func2_r;
  logic [31:0] hx2_r, hy2_r, hz2_r;

  logic signed [32:0] dx, dy, dz;
  logic               in_box;
  logic               keep;
  logic [63:0]        px, py, pz;

  assign adv    = !(v2_r && q_full);
  assign q_push = v2_r && !q_full;

  assign dx = 33'(in_data.pos_x) - 33'(cfg.origin_x);
  assign dy = 33'(in_data.pos_y) - 33'(cfg.origin_y);
  assign dz = 33'(in_data.pos_z) - 33'(cfg.origin_z);

  assign in_box = (in_data.pos_x >= cfg.origin_x) && (in_data.pos_x < cfg.limit_x) &&
                  (in_data.pos_y >= cfg.origin_y) && (in_data.pos_y < cfg.limit_y) &&
                  (in_data.pos_z >= cfg.origin_z) && (in_data.pos_z < cfg.limit_z);
  assign keep   = (in_data.func == FUNC_QUERY) || in_box;

  assign px = 64'(dx1_r) * 64'(cfg.cell_inv);
  assign py = 64'(dy1_r) * 64'(cfg.cell_inv);
  assign pz = 64'(dz1_r) * 64'(cfg.cell_inv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire && keep;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= in_data.func;
      dx1_r   <= dx[32] ? 32'd0 : dx[31:0];
      dy1_r   <= dy[32] ? 32'd0 : dy[31:0];
      dz1_r   <= dz[32] ? 32'd0 : dz[31:0];
      func2_r <= func1_r;
      hx2_r   <= px[63:32];
      hy2_r   <= py[63:32];
      hz2_r   <= pz[63:32];
    end
  end

  always_comb begin
    q_wdata.func = func2_r;
    q_wdata.ix   = sat_idx(hx2_r, X_CELLS);
    q_wdata.iy   = sat_idx(hy2_r, Y_CELLS);
    q_wdata.iz   = sat_idx(hz2_r, Z_CELLS);
  end

endmodule

// ===== rtl/vog_fifo.sv =====
// ----------------------------------------------------------------------------
// vog_fifo
// Small register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module vog_fifo import vog_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     full,
  output logic     empty
);

  q_entry_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/vog_back.sv =====
// ----------------------------------------------------------------------------
// vog_back
// Owns the occupancy memory: clears it, sets marked bits, answers queries.
// ----------------------------------------------------------------------------
module vog_back import vog_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  q_entry_t q_rdata,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     clr_busy,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  localparam int HW = IDX_W + 32;
  localparam int SW = IDX_W + 34;

  logic [Z_CELLS-1:0] mem_r [ROWS];
  logic [Z_CELLS-1:0] rd_r;

  logic              clr_busy_r;
  logic [ROW_AW-1:0] clr_addr_r;

  logic             b1_v_r;
  logic [IDX_W-1:0] b1_ix_r, b1_iy_r, b1_iz_r;
  logic [HW-1:0]    b1_hx_r, b1_hy_r, b1_hz_r;

  logic             out_valid_r;
  out_t             out_data_r;

  logic              adv;
  logic              mark_we;
  logic              rd_en;
  logic [ROW_AW-1:0] row;
  logic [HW:0]       cx, cy, cz;

  function automatic logic [HW:0] half_mul(input logic [IDX_W-1:0] idx,
                                            input logic [31:0] cs);
    half_mul = (HW+1)'({idx, 1'b1}) * (HW+1)'(cs);
  endfunction

  function automatic logic [31:0] sat_add(input logic [HW-1:0] half,
                                          input logic signed [31:0] org);
    logic signed [SW-1:0] s;
    s = $signed(SW'(half)) + SW'(org);
    if (!s[SW-1] && (|s[SW-2:31])) begin
      sat_add = 32'h7FFF_FFFF;
    end else if (s[SW-1] && !(&s[SW-2:31])) begin
      sat_add = 32'h8000_0000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  assign adv      = !(out_valid_r && out_stall);
  assign q_pop    = adv && !q_empty && !clr_busy_r;
  assign mark_we  = q_pop && (q_rdata.func == FUNC_MARK);
  assign rd_en    = q_pop && (q_rdata.func == FUNC_QUERY);
  assign row      = ROW_AW'(q_rdata.ix * Y_CELLS) + ROW_AW'(q_rdata.iy);
  assign clr_busy = clr_busy_r;

  assign cx = half_mul(q_rdata.ix, cfg.cell_size);
  assign cy = half_mul(q_rdata.iy, cfg.cell_size);
  assign cz = half_mul(q_rdata.iz, cfg.cell_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ROW_AW'(ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (mark_we) begin
      mem_r[row][q_rdata.iz[ZW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem_r[row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_v_r      <= rd_en;
      out_valid_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b1_ix_r <= q_rdata.ix;
      b1_iy_r <= q_rdata.iy;
      b1_iz_r <= q_rdata.iz;
      b1_hx_r <= cx[HW:1];
      b1_hy_r <= cy[HW:1];
      b1_hz_r <= cz[HW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b1_v_r) begin
      out_data_r.is_free  <= !rd_r[b1_iz_r[ZW-1:0]];
      out_data_r.cell_x   <= 6'(b1_ix_r);
      out_data_r.cell_y   <= 6'(b1_iy_r);
      out_data_r.cell_z   <= 5'(b1_iz_r);
      out_data_r.centre_x <= sat_add(b1_hx_r, cfg.origin_x);
      out_data_r.centre_y <= sat_add(b1_hy_r, cfg.origin_y);
      out_data_r.centre_z <= sat_add(b1_hz_r, cfg.origin_z);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/voxel_occupancy_grid_core.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_core
// 3-D occupancy bitmap with mark and query items over Q16.16 coordinates.
// ----------------------------------------------------------------------------
// After reset the block clears its occupancy memory one row of Z_CELLS bits
// per cycle, X_CELLS*Y_CELLS = 4096 rows, with in_stall high; configuration
// writes are taken during that pass. Then, unless stalled, it takes one item
// per cycle: the front computes indices in two stages (subtract, then one
// 32x32 multiply per axis), a four-entry queue decouples it from the back,
// and the back makes one access per item to the single-port occupancy memory,
// which sets the sustained rate of one item per cycle. A query result passes
// both front stages, the queue and the back's read and output registers; a
// mark gives none. The front drops marks outside the box [origin, limit).
module voxel_occupancy_grid_core import vog_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_wdata, q_rdata;
  logic     front_adv;
  logic     clr_busy;
  logic     in_fire;

  assign in_stall = !front_adv || clr_busy;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= RST_ORIGIN;
      cfg_r.origin_y  <= RST_ORIGIN;
      cfg_r.origin_z  <= RST_ORIGIN;
      cfg_r.limit_x   <= RST_LIMIT_XY;
      cfg_r.limit_y   <= RST_LIMIT_XY;
      cfg_r.limit_z   <= RST_LIMIT_Z;
      cfg_r.cell_size <= RST_CELL_SIZE;
      cfg_r.cell_inv  <= RST_CELL_INV;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORIGIN_X:  cfg_r.origin_x  <= cfg_wdata;
        REG_ORIGIN_Y:  cfg_r.origin_y  <= cfg_wdata;
        REG_ORIGIN_Z:  cfg_r.origin_z  <= cfg_wdata;
        REG_LIMIT_X:   cfg_r.limit_x   <= cfg_wdata;
        REG_LIMIT_Y:   cfg_r.limit_y   <= cfg_wdata;
        REG_LIMIT_Z:   cfg_r.limit_z   <= cfg_wdata;
        REG_CELL_SIZE: cfg_r.cell_size <= cfg_wdata;
        REG_CELL_INV:  cfg_r.cell_inv  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  vog_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_data (in_data),
    .q_full  (q_full),
    .adv     (front_adv),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  vog_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  vog_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/vog_checker.sv =====
// ----------------------------------------------------------------------------
// vog_checker
// Port-level checks on the voxel occupancy grid core, bound to the top level.
// ----------------------------------------------------------------------------
module vog_checker import vog_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken before memory clear");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_result_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_stall, 1) && $past(in_stall, 2) && $past(in_stall, 3) &&
    $past(in_stall, 4) && $past(in_stall, 5) && $past(!rst_n, 6) |-> !out_valid)
    else $error("result shown while memory clear runs");

endmodule

bind voxel_occupancy_grid_core vog_checker u_vog_checker (.*);

// ===== verif/voxel_occupancy_grid_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_core_test
// Self-checking bench for the voxel occupancy grid core. Mark and query
// transfers go in under random idling and back pressure on both channels.
// A behavioral copy of the bitmap and the registers predicts every query
// result, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module voxel_occupancy_grid_core_test import vog_pkg::*; ();

  typedef longint unsigned u64_t;

  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam cfg_t RESET_CFG = cfg_t'{RST_ORIGIN, RST_ORIGIN, RST_ORIGIN, RST_LIMIT_XY,
                                      RST_LIMIT_XY, RST_LIMIT_Z, RST_CELL_SIZE, RST_CELL_INV};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  bit   occupied [X_CELLS*Y_CELLS*Z_CELLS];
  cfg_t cur;
  out_t pending_results[$];
  in_t  recent_marks[$];
  int   mismatches = 0;
  bit   sender_idle_on;
  bit   receiver_idle_on;
  int   hold_request = 0;

  always #5 clk = ~clk;

  voxel_occupancy_grid_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  function automatic logic signed [31:0] clamp_q(longint v);
    if (v > Q_MAX) begin
      v = Q_MAX;
    end
    if (v < Q_MIN) begin
      v = Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic int unsigned axis_cell(logic signed [31:0] pos, logic signed [31:0] org,
                                            int unsigned cells);
    longint d;
    u64_t   prod;
    d = longint'(pos) - longint'(org);
    if (d < 0) begin
      return 0;
    end
    prod = (u64_t'(d) * u64_t'(cur.cell_inv)) >> 32;
    if (prod > cells - 1) begin
      return cells - 1;
    end
    return prod[31:0];
  endfunction

  function automatic logic signed [31:0] cell_centre(int unsigned idx, logic signed [31:0] org);
    u64_t half;
    half = (u64_t'(2 * idx + 1) * u64_t'(cur.cell_size)) >> 1;
    return clamp_q(longint'(half) + longint'(org));
  endfunction

  function automatic void apply_item(in_t item);
    int unsigned ix, iy, iz, addr;
    out_t        res;
    ix   = axis_cell(item.pos_x, cur.origin_x, X_CELLS);
    iy   = axis_cell(item.pos_y, cur.origin_y, Y_CELLS);
    iz   = axis_cell(item.pos_z, cur.origin_z, Z_CELLS);
    addr = (ix * Y_CELLS + iy) * Z_CELLS + iz;
    if (item.func == FUNC_MARK) begin
      if ($signed(item.pos_x) >= $signed(cur.origin_x) &&
          $signed(item.pos_y) >= $signed(cur.origin_y) &&
          $signed(item.pos_z) >= $signed(cur.origin_z) &&
          $signed(item.pos_x) < $signed(cur.limit_x) &&
          $signed(item.pos_y) < $signed(cur.limit_y) &&
          $signed(item.pos_z) < $signed(cur.limit_z)) begin
        occupied[addr] = 1'b1;
      end
    end else begin
      res.is_free  = !occupied[addr];
      res.cell_x   = ix[5:0];
      res.cell_y   = iy[5:0];
      res.cell_z   = iz[4:0];
      res.centre_x = cell_centre(ix, cur.origin_x);
      res.centre_y = cell_centre(iy, cur.origin_y);
      res.centre_z = cell_centre(iz, cur.origin_z);
      pending_results.push_back(res);
    end
  endfunction

  function automatic logic signed [31:0] near_grid(logic signed [31:0] org,
                                                   logic signed [31:0] lim, int unsigned cells);
    longint p;
    longint cs;
    cs = longint'(cur.cell_size);
    case ($urandom_range(0, 11))
      0: p = longint'($signed($urandom()));
      1: p = longint'(org) - longint'($urandom_range(1, 4 * 65536));
      2: p = longint'(lim) - 1;
      3: p = longint'(lim);
      4: p = longint'(org) + longint'(cells) * cs + longint'($urandom_range(0, 8 * 65536));
      5: p = longint'(org) + longint'($urandom_range(0, cells - 1)) * cs;
      default: p = longint'(org) + longint'($urandom_range(0, cells - 1)) * cs +
                   ((cs * longint'($urandom_range(0, 65535))) >>> 16);
    endcase
    return clamp_q(p);
  endfunction

  function automatic in_t random_item();
    in_t it;
    if (recent_marks.size() != 0 && $urandom_range(0, 3) == 0) begin
      it      = recent_marks[$urandom_range(0, recent_marks.size() - 1)];
      it.func = ($urandom_range(0, 4) == 0) ? FUNC_MARK : FUNC_QUERY;
    end else begin
      it.func  = ($urandom_range(0, 1) == 0) ? FUNC_MARK : FUNC_QUERY;
      it.pos_x = near_grid(cur.origin_x, cur.limit_x, X_CELLS);
      it.pos_y = near_grid(cur.origin_y, cur.limit_y, Y_CELLS);
      it.pos_z = near_grid(cur.origin_z, cur.limit_z, Z_CELLS);
    end
    return it;
  endfunction

  function automatic void pick_bounds(input int unsigned cells, input logic [31:0] cs,
                                      output logic signed [31:0] org,
                                      output logic signed [31:0] lim);
    longint span;
    case ($urandom_range(0, 7))
      0:       org = '0;
      1:       org = POS_MIN;
      2:       org = $signed($urandom());
      default: org = clamp_q(longint'($urandom_range(0, 128 * 65536)) - 64 * 65536);
    endcase
    span = longint'(cells) * longint'(cs);
    case ($urandom_range(0, 7))
      0:       lim = POS_MAX;
      1:       lim = clamp_q(longint'(org) - longint'($urandom_range(0, 65536)));
      2:       lim = clamp_q(longint'(org) + span / 2);
      default: lim = clamp_q(longint'(org) + span + longint'($urandom_range(0, 3)) * longint'(cs));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    logic [31:0] cs;
    case ($urandom_range(0, 7))
      0: cs = 32'h0001_0000;
      1: cs = 32'h0000_8000;
      2: cs = 32'h0000_4000;
      3: cs = 32'h0001_8000;
      4: cs = 32'h0004_0000;
      5: cs = $urandom_range(1, 32'h0010_0000);
      6: cs = 32'hFFFF_FFFF;
      default: cs = $urandom_range(1, 255);
    endcase
    c.cell_size = cs;
    c.cell_inv  = (cs == 32'd1) ? 32'hFFFF_FFFF : 32'(64'h1_0000_0000 / cs);
    if ($urandom_range(0, 3) == 0) begin
      c.cell_inv = c.cell_inv + 32'($urandom_range(0, 1));
    end
    pick_bounds(X_CELLS, cs, c.origin_x, c.limit_x);
    pick_bounds(Y_CELLS, cs, c.origin_y, c.limit_y);
    pick_bounds(Z_CELLS, cs, c.origin_z, c.limit_z);
    return c;
  endfunction

  task automatic send_item(in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(item);
    if (item.func == FUNC_MARK) begin
      recent_marks.push_back(item);
      if (recent_marks.size() > 32) begin
        recent_marks.pop_front();
      end
    end
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    // let marks still in the pipeline retire before the registers move
    wait_results();
    repeat (20) @(posedge clk);
    write_reg(REG_ORIGIN_X, c.origin_x);
    write_reg(REG_ORIGIN_Y, c.origin_y);
    write_reg(REG_ORIGIN_Z, c.origin_z);
    write_reg(REG_LIMIT_X, c.limit_x);
    write_reg(REG_LIMIT_Y, c.limit_y);
    write_reg(REG_LIMIT_Z, c.limit_z);
    write_reg(REG_CELL_SIZE, c.cell_size);
    write_reg(REG_CELL_INV, c.cell_inv);
    cfg_we <= 1'b0;
    cur = c;
  endtask

  task automatic test_defaults();
    load_config(RESET_CFG);
    send_item(in_t'{FUNC_QUERY, 32'sd0, 32'sd0, 32'sd0});
    send_item(in_t'{FUNC_MARK, 32'sd0, 32'sd0, 32'sd0});
    send_item(in_t'{FUNC_QUERY, 32'sh8000, 32'sh8000, 32'sh8000});
    send_item(in_t'{FUNC_QUERY, POS_MAX, POS_MAX, POS_MAX});
    send_item(in_t'{FUNC_QUERY, POS_MIN, POS_MIN, POS_MIN});
    send_item(in_t'{FUNC_MARK, POS_MIN, ONE, ONE});
    send_item(in_t'{FUNC_MARK, 32'sh0040_0000, ONE, ONE});
    send_item(in_t'{FUNC_MARK, ONE, ONE, 32'sh0020_0000});
    send_item(in_t'{FUNC_MARK, 32'sh003F_FFFF, 32'sh003F_FFFF, 32'sh001F_FFFF});
    send_item(in_t'{FUNC_QUERY, 32'sh003F_0000, 32'sh003F_0000, 32'sh001F_0000});
    send_item(in_t'{FUNC_MARK, ONE, POS_MAX, ONE});
    send_item(in_t'{FUNC_QUERY, ONE, ONE, ONE});
  endtask

  task automatic test_past_grid();
    load_config(cfg_t'{-32'sh0004_0000, 32'sd0, 32'sd0, POS_MAX, POS_MAX, POS_MAX,
                       RST_CELL_SIZE, RST_CELL_INV});
    send_item(in_t'{FUNC_MARK, 32'sh0064_0000, 32'sh0005_0000, 32'sh0028_0000});
    send_item(in_t'{FUNC_QUERY, 32'sh00C8_0000, 32'sh0005_8000, 32'sh03E7_0000});
  endtask

  task automatic test_extreme_registers();
    load_config(cfg_t'{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item(in_t'{FUNC_MARK, 32'sh7FFF_FFFE, POS_MIN, 32'sd0});
    send_item(in_t'{FUNC_QUERY, POS_MAX, POS_MIN, 32'sd0});
    load_config(cfg_t'{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
                       RST_CELL_SIZE, RST_CELL_INV});
    send_item(in_t'{FUNC_MARK, POS_MAX, POS_MAX, POS_MAX});
    send_item(in_t'{FUNC_QUERY, POS_MAX, POS_MAX, POS_MAX});
    send_item(in_t'{FUNC_QUERY, 32'sd0, 32'sd0, 32'sd0});
  endtask

  task automatic test_zero_scale();
    load_config(cfg_t'{ONE, 32'sh0002_0000, 32'sh0003_0000, RST_LIMIT_XY, RST_LIMIT_XY,
                       RST_LIMIT_Z, 32'd0, 32'd0});
    send_item(in_t'{FUNC_MARK, 32'sh000A_0000, 32'sh0014_0000, 32'sh001E_0000});
    send_item(in_t'{FUNC_QUERY, 32'sh0032_0000, 32'sh0032_0000, 32'sh0014_0000});
  endtask

  task automatic test_back_pressure();
    in_t it;
    load_config(RESET_CFG);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    hold_request     = 300;
    repeat (40) begin
      it      = random_item();
      it.func = FUNC_QUERY;
      send_item(it);
    end
    // hold the sender until the backlog is gone
    wait_results();
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (20) send_item(random_item());
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      sender_idle_on   = (phase % 3) != 1 && phase != 5;
      receiver_idle_on = (phase % 3) != 2 && phase != 5;
      load_config(random_config());
      repeat (245) send_item(random_item());
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result with nothing pending: %h", $time, out_data);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.is_free !== want.is_free || out_data.cell_x !== want.cell_x ||
            out_data.cell_y !== want.cell_y || out_data.cell_z !== want.cell_z ||
            out_data.centre_x !== want.centre_x || out_data.centre_y !== want.centre_y ||
            out_data.centre_z !== want.centre_z) begin
          if (mismatches < 10) begin
            $display("%0t: result mismatch: expected free=%0b cell=%0d/%0d/%0d centre=%h/%h/%h",
                     $time, want.is_free, want.cell_x, want.cell_y, want.cell_z,
                     want.centre_x, want.centre_y, want.centre_z);
            $display("    actual free=%0b cell=%0d/%0d/%0d centre=%h/%h/%h",
                     out_data.is_free, out_data.cell_x, out_data.cell_y, out_data.cell_z,
                     out_data.centre_x, out_data.centre_y, out_data.centre_z);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    cur = RESET_CFG;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_past_grid();
    test_extreme_registers();
    test_zero_scale();
    test_back_pressure();
    test_random_traffic();
    wait_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
